// File: rtl/core/cicd_pkg.sv
// Shared types and constants for the coin inventory change dispenser.
// No dependencies; imported by every module of the block.
package cicd_pkg;

	localparam int FIELD_W = 16;
	localparam int COST_W  = 22;

	localparam logic [COST_W-1:0] TOTAL_MAX = {COST_W{1'b1}};

	// floor(2^22 / d), one correction step afterwards
	localparam logic [19:0] RECIP5  = 20'd838860;
	localparam logic [17:0] RECIP25 = 18'd167772;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NO_FUNDS  = 2'd1,
		ST_NO_CHANGE = 2'd2
	} status_t;

	// cost split by constant divisors
	typedef struct packed {
		logic [19:0] fifths;    // cost / 5
		logic [2:0]  rem5;      // cost % 5
		logic [17:0] quarters;  // cost / 25
	} split_t;

	typedef struct packed {
		status_t            status;
		logic [FIELD_W-1:0] quarters_paid;
		logic [FIELD_W-1:0] dimes_paid;
		logic [FIELD_W-1:0] nickels_paid;
		logic [FIELD_W-1:0] pennies_paid;
		logic [FIELD_W-1:0] quarters_held;
		logic [FIELD_W-1:0] dimes_held;
		logic [FIELD_W-1:0] nickels_held;
		logic [FIELD_W-1:0] pennies_held;
		logic [COST_W-1:0]  total_cents;
	} res_t;

endpackage

// File: rtl/core/cicd_presplit.sv
// Divides the requested cost by 5 and by 25 with reciprocal multiplies.
// Depends on cicd_pkg.
module cicd_presplit (
	input  logic [21:0]     cost_cents,
	output cicd_pkg::split_t split
);
	import cicd_pkg::*;

	logic [41:0]       prod5;
	logic [39:0]       prod25;
	logic [19:0]       q5_raw;
	logic [17:0]       q25_raw;
	logic [COST_W-1:0] r5_raw;
	logic [COST_W-1:0] r25_raw;
	logic              fix5;
	logic              fix25;

	assign prod5   = {20'b0, cost_cents} * {22'b0, RECIP5};
	assign prod25  = {18'b0, cost_cents} * {22'b0, RECIP25};
	assign q5_raw  = prod5[41:22];
	assign q25_raw = prod25[39:22];

	assign r5_raw  = cost_cents - (({2'b0, q5_raw} << 2) + {2'b0, q5_raw});
	assign r25_raw = cost_cents - ({4'b0, q25_raw} * 22'd25);
	assign fix5    = r5_raw >= 22'd5;
	assign fix25   = r25_raw >= 22'd25;

	assign split.fifths   = q5_raw + {19'b0, fix5};
	assign split.rem5     = fix5 ? 3'(r5_raw - 22'd5) : 3'(r5_raw);
	assign split.quarters = q25_raw + {17'b0, fix25};

endmodule

// File: rtl/core/cicd_ledger.sv
// Coin stock registers, deposit saturation and the greedy change pass.
// Depends on cicd_pkg; the cost arrives pre-split by cicd_presplit.
module cicd_ledger #(
	parameter int COUNT_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     commit,
	input  logic                     command,
	input  logic [15:0]              add_quarters,
	input  logic [15:0]              add_dimes,
	input  logic [15:0]              add_nickels,
	input  logic [15:0]              add_pennies,
	input  logic [21:0]              cost_cents,
	input  cicd_pkg::split_t         split,
	output cicd_pkg::res_t           result
);
	import cicd_pkg::*;

	localparam int CB  = COUNT_BITS;
	localparam int EVW = CB + 6;
	localparam int CW  = (EVW > COST_W) ? EVW : COST_W;
	localparam int SW  = ((CB > FIELD_W) ? CB : FIELD_W) + 1;
	localparam logic [CB-1:0] CMAX = {CB{1'b1}};

	logic [CB-1:0]  q_cnt_q, d_cnt_q, n_cnt_q, p_cnt_q;
	logic [EVW-1:0] ev_q;

	logic [CB-1:0]  q_nxt, d_nxt, n_nxt, p_nxt;
	logic [CB-1:0]  q_dep, d_dep, n_dep, p_dep;
	logic [EVW-1:0] ev_nxt, ev_dep;

	logic [CW-1:0]  cost_x, ev_x, qf_x, qh_x, dh_x, nh_x, ph_x;
	logic [CW-1:0]  q_x, k1, d_x, k2, n_x, k3, owed, ev_nxt_x;
	logic           funds_ok, change_ok, paid_ok;
	status_t        status;

	function automatic logic [CB-1:0] add_sat(logic [CB-1:0] held, logic [15:0] more);
		logic [SW-1:0] s;
		s = SW'(held) + SW'(more);
		return (s > SW'(CMAX)) ? CMAX : CB'(s);
	endfunction

	function automatic logic [EVW-1:0] weigh(logic [CB-1:0] q, logic [CB-1:0] d,
			logic [CB-1:0] n, logic [CB-1:0] p);
		logic [EVW-1:0] qe, de, ne, pe;
		qe = EVW'(q);
		de = EVW'(d);
		ne = EVW'(n);
		pe = EVW'(p);
		return (qe << 4) + (qe << 3) + qe + (de << 3) + (de << 1) + (ne << 2) + ne + pe;
	endfunction

	always_comb begin
		cost_x = CW'(cost_cents);
		ev_x   = CW'(ev_q);
		qf_x   = CW'(split.quarters);
		qh_x   = CW'(q_cnt_q);
		dh_x   = CW'(d_cnt_q);
		nh_x   = CW'(n_cnt_q);
		ph_x   = CW'(p_cnt_q);

		funds_ok = ev_x >= cost_x;
		// work in five-cent units owed: quarter takes 5, dime 2, nickel 1
		q_x  = (qf_x < qh_x) ? qf_x : qh_x;
		k1   = CW'(split.fifths) - ((q_x << 2) + q_x);
		d_x  = ((k1 >> 1) < dh_x) ? (k1 >> 1) : dh_x;
		k2   = k1 - (d_x << 1);
		n_x  = (k2 < nh_x) ? k2 : nh_x;
		k3   = k2 - n_x;
		owed = (k3 << 2) + k3 + CW'(split.rem5);
		change_ok = owed <= ph_x;

		q_dep  = add_sat(q_cnt_q, add_quarters);
		d_dep  = add_sat(d_cnt_q, add_dimes);
		n_dep  = add_sat(n_cnt_q, add_nickels);
		p_dep  = add_sat(p_cnt_q, add_pennies);
		ev_dep = weigh(q_dep, d_dep, n_dep, p_dep);

		paid_ok = 1'b0;
		q_nxt   = q_cnt_q;
		d_nxt   = d_cnt_q;
		n_nxt   = n_cnt_q;
		p_nxt   = p_cnt_q;
		ev_nxt  = ev_q;
		status  = ST_OK;
		if (!command) begin
			q_nxt  = q_dep;
			d_nxt  = d_dep;
			n_nxt  = n_dep;
			p_nxt  = p_dep;
			ev_nxt = ev_dep;
		end else if (!funds_ok) begin
			status = ST_NO_FUNDS;
		end else if (!change_ok) begin
			status = ST_NO_CHANGE;
		end else begin
			paid_ok = 1'b1;
			q_nxt   = q_cnt_q - CB'(q_x);
			d_nxt   = d_cnt_q - CB'(d_x);
			n_nxt   = n_cnt_q - CB'(n_x);
			p_nxt   = p_cnt_q - CB'(owed);
			ev_nxt  = EVW'(ev_x - cost_x);
		end
		ev_nxt_x = CW'(ev_nxt);

		result.status        = status;
		result.quarters_paid = paid_ok ? 16'(q_x) : '0;
		result.dimes_paid    = paid_ok ? 16'(d_x) : '0;
		result.nickels_paid  = paid_ok ? 16'(n_x) : '0;
		result.pennies_paid  = paid_ok ? 16'(owed) : '0;
		result.quarters_held = 16'(CW'(q_nxt));
		result.dimes_held    = 16'(CW'(d_nxt));
		result.nickels_held  = 16'(CW'(n_nxt));
		result.pennies_held  = 16'(CW'(p_nxt));
		result.total_cents   = (ev_nxt_x > CW'(TOTAL_MAX)) ? TOTAL_MAX : 22'(ev_nxt_x);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_cnt_q <= '0;
			d_cnt_q <= '0;
			n_cnt_q <= '0;
			p_cnt_q <= '0;
			ev_q    <= '0;
		end else if (commit) begin
			q_cnt_q <= q_nxt;
			d_cnt_q <= d_nxt;
			n_cnt_q <= n_nxt;
			p_cnt_q <= p_nxt;
			ev_q    <= ev_nxt;
		end
	end

endmodule

// File: rtl/core/coin_inventory_change_dispenser.sv
// Top level of the coin inventory change dispenser: stream ports, input and result registers.
// Depends on cicd_pkg, cicd_presplit and cicd_ledger.
//
// channel | dir | tdata (low bit up)                                   | tuser
// s_      | in  | add_quarters, add_dimes, add_nickels, add_pennies,   | command
//         |     | cost_cents, zero pad to 88 bits                      |
// m_      | out | quarters/dimes/nickels/pennies_paid, quarters/dimes/ | status
//         |     | nickels/pennies_held, total_cents, zero pad to 152   |
//
// One request per cycle while m_ is not stalled; s_ accept reaches m_tvalid through the input and result registers.
// The cost is split by 5 and 25 on the way into the input register; the stock
// update and greedy pass sit between the input and result registers.
// Reset clears the stock and both valid flags; the stock needs no sweep.
// A stalled m_ side holds the result; s_tready drops only when both stages are full.
module coin_inventory_change_dispenser #(
	parameter int COUNT_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [87:0]  s_tdata,   // add_quarters, add_dimes, add_nickels, add_pennies, cost_cents
	input  logic         s_tuser,   // command
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [151:0] m_tdata,   // paid q/d/n/p, held q/d/n/p, total_cents
	output logic [1:0]   m_tuser    // status
);
	import cicd_pkg::*;

	logic        valid_s1;
	logic        cmd_s1;
	logic [15:0] addq_s1, addd_s1, addn_s1, addp_s1;
	logic [21:0] cost_s1;
	split_t      split_s1;
	split_t      split_in;

	res_t        result;
	res_t        result_q;
	logic        m_valid_q;
	logic        advance;
	logic        commit;

	assign advance  = !m_valid_q || m_tready;
	assign commit   = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;

	cicd_presplit u_presplit (
		.cost_cents (s_tdata[85:64]),
		.split      (split_in)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1   <= s_tuser;
			addq_s1  <= s_tdata[15:0];
			addd_s1  <= s_tdata[31:16];
			addn_s1  <= s_tdata[47:32];
			addp_s1  <= s_tdata[63:48];
			cost_s1  <= s_tdata[85:64];
			split_s1 <= split_in;
		end
	end

	cicd_ledger #(
		.COUNT_BITS (COUNT_BITS)
	) u_ledger (
		.clk          (clk),
		.arst_n       (arst_n),
		.commit       (commit),
		.command      (cmd_s1),
		.add_quarters (addq_s1),
		.add_dimes    (addd_s1),
		.add_nickels  (addn_s1),
		.add_pennies  (addp_s1),
		.cost_cents   (cost_s1),
		.split        (split_s1),
		.result       (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			result_q <= result;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = result_q.status;
	assign m_tdata  = {2'b0, result_q.total_cents,
		result_q.pennies_held, result_q.nickels_held,
		result_q.dimes_held, result_q.quarters_held,
		result_q.pennies_paid, result_q.nickels_paid,
		result_q.dimes_paid, result_q.quarters_paid};

	a_ready_low: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && m_valid_q && !m_tready))
		else $error("s_tready low without a full stalled pipeline");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> valid_s1)
		else $error("input stage lost a request while stalled");

	a_fail_pays_nothing: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && result_q.status != ST_OK) |-> (m_tdata[63:0] == 64'd0))
		else $error("failed withdrawal reports coins paid");

endmodule

// File: test/tb_top.sv
// Self-checking testbench for coin_inventory_change_dispenser: directed and random
// deposit/withdraw requests with a scoreboard class that predicts every result.
// Depends on cicd_pkg and the RTL of the block only.
`timescale 1ns / 100ps

module tb_top;
	import cicd_pkg::*;

	localparam logic CMD_DEPOSIT  = 1'b0;
	localparam logic CMD_WITHDRAW = 1'b1;
	localparam int   HOLD_CYCLES  = 300;
	localparam int   IDLE_PCT     = 14;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [87:0]  s_tdata = '0;    // add_quarters, add_dimes, add_nickels, add_pennies, cost_cents
	logic         s_tuser = 1'b0;  // command
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [151:0] m_tdata;         // paid q/d/n/p, held q/d/n/p, total_cents
	logic [1:0]   m_tuser;         // status

	bit stall_on = 1'b1;
	bit hold_off_req = 1'b0;

	// Tracks the coin stock and the queue of results still owed by the block.
	class change_ledger_sb;
		bit [15:0] quarters, dimes, nickels, pennies;
		res_t      owed_results[$];
		int        errors;

		function longint unsigned stock_value();
			return 25 * longint'(quarters) + 10 * longint'(dimes)
				+ 5 * longint'(nickels) + longint'(pennies);
		endfunction

		function bit [15:0] sat_add(bit [15:0] held, bit [15:0] more);
			int unsigned s;
			s = held + more;
			return (s > 16'hFFFF) ? 16'hFFFF : s[15:0];
		endfunction

		function int pending();
			return owed_results.size();
		endfunction

		function void note_request(logic cmd, logic [87:0] data);
			res_t            r;
			int unsigned     owed, q, d, n;
			longint unsigned worth;
			r = '0;
			r.status = ST_OK;
			if (cmd == CMD_DEPOSIT) begin
				quarters = sat_add(quarters, data[15:0]);
				dimes    = sat_add(dimes, data[31:16]);
				nickels  = sat_add(nickels, data[47:32]);
				pennies  = sat_add(pennies, data[63:48]);
			end else begin
				owed = 32'(data[85:64]);
				if (stock_value() < owed) begin
					r.status = ST_NO_FUNDS;
				end else begin
					q = owed / 25;
					if (q > quarters) q = 32'(quarters);
					owed -= q * 25;
					d = owed / 10;
					if (d > dimes) d = 32'(dimes);
					owed -= d * 10;
					n = owed / 5;
					if (n > nickels) n = 32'(nickels);
					owed -= n * 5;
					if (owed <= pennies) begin
						quarters = quarters - 16'(q);
						dimes    = dimes - 16'(d);
						nickels  = nickels - 16'(n);
						pennies  = pennies - 16'(owed);
						r.quarters_paid = 16'(q);
						r.dimes_paid    = 16'(d);
						r.nickels_paid  = 16'(n);
						r.pennies_paid  = 16'(owed);
					end else begin
						r.status = ST_NO_CHANGE;
					end
				end
			end
			r.quarters_held = quarters;
			r.dimes_held    = dimes;
			r.nickels_held  = nickels;
			r.pennies_held  = pennies;
			worth = stock_value();
			r.total_cents = (worth > TOTAL_MAX) ? TOTAL_MAX : worth[21:0];
			owed_results.push_back(r);
		endfunction

		function void cmp_field(string name, longint unsigned want, longint unsigned got);
			if (want != got) begin
				$error("%s: expected %0d, actual %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(logic [1:0] status, logic [151:0] data);
			res_t want;
			if (owed_results.size() == 0) begin
				$error("result with no request outstanding");
				errors++;
				return;
			end
			want = owed_results.pop_front();
			cmp_field("status", want.status, status);
			cmp_field("quarters_paid", want.quarters_paid, data[15:0]);
			cmp_field("dimes_paid", want.dimes_paid, data[31:16]);
			cmp_field("nickels_paid", want.nickels_paid, data[47:32]);
			cmp_field("pennies_paid", want.pennies_paid, data[63:48]);
			cmp_field("quarters_held", want.quarters_held, data[79:64]);
			cmp_field("dimes_held", want.dimes_held, data[95:80]);
			cmp_field("nickels_held", want.nickels_held, data[111:96]);
			cmp_field("pennies_held", want.pennies_held, data[127:112]);
			cmp_field("total_cents", want.total_cents, data[149:128]);
		endfunction
	endclass

	change_ledger_sb sb = new();

	coin_inventory_change_dispenser dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tuser, m_tdata);
	end

	// receiver: random stalls, or a long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
			end else begin
				m_tready <= !(stall_on && $urandom_range(0, 99) < IDLE_PCT);
			end
		end
	end

	task automatic offer(input logic cmd, input logic [87:0] data);
		if (stall_on && $urandom_range(0, 99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= data;
		do @(posedge clk); while (!s_tready);
		sb.note_request(cmd, data);
	endtask

	// unused fields carry random junk; the block must ignore them
	task automatic deposit(input logic [15:0] q, d, n, p);
		offer(CMD_DEPOSIT, {2'b00, 22'($urandom), p, n, d, q});
	endtask

	task automatic withdraw(input logic [21:0] cost);
		offer(CMD_WITHDRAW, {2'b00, cost, 16'($urandom), 16'($urandom),
			16'($urandom), 16'($urandom)});
	endtask

	task automatic drain_pause();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	function automatic logic [15:0] coin_count();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 65) return 16'($urandom_range(0, 30));
		if (r < 80) return 16'($urandom_range(0, 16'hFFFF));
		return '0;
	endfunction

	task automatic random_request();
		longint unsigned held;
		int unsigned     r;
		logic [21:0]     cost;
		held = sb.stock_value();
		if ($urandom_range(0, 99) < 45) begin
			deposit(coin_count(), coin_count(), coin_count(), coin_count());
		end else begin
			r = $urandom_range(0, 99);
			if (r < 50)
				cost = (held == 0) ? 22'd0 : 22'($urandom_range(0, int'(held)));
			else if (r < 70)
				cost = 22'($urandom_range(0, 120));
			else if (r < 85)
				cost = 22'($urandom_range(0, 22'h3FFFFF));
			else
				cost = 22'(held + $urandom_range(1, 50));
			withdraw(cost);
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		withdraw(22'd0);
		withdraw(22'd1);
		deposit(16'd0, 16'd0, 16'd0, 16'd0);
		deposit(16'd3, 16'd0, 16'd0, 16'd0);
		withdraw(22'd30);                       // short of pennies
		deposit(16'd0, 16'd2, 16'd1, 16'd4);
		withdraw(22'd44);
		withdraw(22'h3FFFFF);                   // far beyond funds
		deposit(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		deposit(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		withdraw(22'd2686935);                  // empties the full stock, every coin capped
		withdraw(22'd0);
		deposit(16'd1, 16'd1, 16'd1, 16'd1);
		withdraw(22'd41);
		deposit(16'd0, 16'd3, 16'd0, 16'd2);
		withdraw(22'd29);
		withdraw(22'd22);
		deposit(16'd1, 16'd0, 16'd0, 16'd100);
		withdraw(22'd75);
		withdraw(22'd51);

		repeat (150) random_request();
		stall_on = 1'b0;
		repeat (120) random_request();
		stall_on = 1'b1;
		hold_off_req = 1'b1;
		repeat (60) random_request();
		drain_pause();
		repeat (100) random_request();
		s_tvalid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
